FILE: rtl/length_prefixed_request_parser_macros.svh
// Assertion macros used by the parser core.
`ifndef LENGTH_PREFIXED_REQUEST_PARSER_MACROS_SVH
`define LENGTH_PREFIXED_REQUEST_PARSER_MACROS_SVH
`ifndef SYNTH
// Checked on every clock edge outside reset.
`define LPRP_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define LPRP_ASSERT_AR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPRP_ASSERT(label, clk, rstn, prop, msg)
`define LPRP_ASSERT_AR(label, clk, prop, msg)
`endif
`endif

FILE: rtl/lprp_pkg.sv
package lprp_pkg;

  // Width of the length, count and index counters.
  localparam int unsigned CountWidth = 21;
  localparam logic [31:0] CntMax = 32'((64'd1 << CountWidth) - 64'd1);
  localparam logic [CountWidth-1:0] MaxMessageReset = CountWidth'(4096);

  // Verdict codes.
  localparam logic [2:0] VerdictNone    = 3'd0;
  localparam logic [2:0] VerdictGet     = 3'd1;
  localparam logic [2:0] VerdictSet     = 3'd2;
  localparam logic [2:0] VerdictDel     = 3'd3;
  localparam logic [2:0] VerdictUnknown = 3'd4;
  localparam logic [2:0] VerdictBad     = 3'd5;
  localparam logic [2:0] VerdictLong    = 3'd6;

  // One input transaction.
  typedef struct packed {
    logic       connection_start;
    logic [7:0] stream_byte;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0]            byte_out;
    logic                  payload_valid;
    logic [CountWidth-1:0] string_number;
    logic                  string_last;
    logic                  frame_end;
    logic [2:0]            verdict;
    logic                  stream_closed;
  } result_t;

  // Command letters, row per command (get, set, del), column per offset.
  localparam logic [2:0][2:0][7:0] CmdChars = '{
    '{8'h6c, 8'h65, 8'h64},
    '{8'h74, 8'h65, 8'h73},
    '{8'h74, 8'h65, 8'h67}
  };

  // Folds A-Z to a-z; every other byte is left alone.
  function automatic logic [7:0] fold_case(logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5a) begin
      return b + 8'h20;
    end
    return b;
  endfunction

endpackage

FILE: rtl/lprp_if.sv
// Byte stream channel into the parser.
interface lprp_in_if;
  logic       valid;
  logic       ready;
  logic       connection_start;
  logic [7:0] stream_byte;

  modport source(output valid, output connection_start, output stream_byte, input ready);
  modport sink(input valid, input connection_start, input stream_byte, output ready);
endinterface

// Tagged byte channel out of the parser.
interface lprp_out_if;
  logic                              valid;
  logic                              ready;
  logic [7:0]                        byte_out;
  logic                              payload_valid;
  logic [lprp_pkg::CountWidth-1:0]   string_number;
  logic                              string_last;
  logic                              frame_end;
  logic [2:0]                        verdict;
  logic                              stream_closed;

  modport source(output valid, output byte_out, output payload_valid, output string_number,
                 output string_last, output frame_end, output verdict,
                 output stream_closed, input ready);
  modport sink(input valid, input byte_out, input payload_valid, input string_number,
               input string_last, input frame_end, input verdict,
               input stream_closed, output ready);
endinterface

FILE: rtl/lprp_core.sv
`include "length_prefixed_request_parser_macros.svh"

// Frame parsing state and the per-byte step logic.
module lprp_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  lprp_pkg::item_t                 item_i,
  input  logic [lprp_pkg::CountWidth-1:0] max_message_i,
  output lprp_pkg::result_t               result_o
);

  localparam int unsigned CW = lprp_pkg::CountWidth;

  typedef enum logic [2:0] {
    PhLen,
    PhCnt,
    PhShdr,
    PhSdata,
    PhTail
  } phase_e;

  phase_e        phase_q, phase_d, c_phase;
  logic [1:0]    hdr_q, hdr_d, c_hdr;
  logic [31:0]   shift_q, shift_d, c_shift;
  logic [CW-1:0] flen_q, flen_d, c_flen;
  logic [CW-1:0] fpos_q, fpos_d, c_fpos;
  logic [CW-1:0] sleft_q, sleft_d, c_sleft;
  logic [CW-1:0] sbytes_q, sbytes_d, c_sbytes;
  logic [CW-1:0] sidx_q, sidx_d, c_sidx;
  logic [CW-1:0] scount_q, scount_d, c_scount;
  logic [2:0]    cmd_q, cmd_d, c_cmd;
  logic          ferr_q, ferr_d, c_ferr;
  logic          closed_q, closed_d, c_closed;

  logic [31:0]   full;
  logic          done;
  logic          too_big;
  logic [CW-1:0] pos1;
  logic          last;
  logic [CW-1:0] sleft_m1;
  logic [CW-1:0] sidx_p1;
  logic [CW-1:0] sbytes_m1;
  logic [1:0]    off;
  logic [7:0]    low;
  lprp_pkg::result_t res;

  // Step logic for one byte.
  always_comb begin
    // A connection start clears the parse state before this byte.
    c_phase  = phase_q;
    c_hdr    = hdr_q;
    c_shift  = shift_q;
    c_flen   = flen_q;
    c_fpos   = fpos_q;
    c_sleft  = sleft_q;
    c_sbytes = sbytes_q;
    c_sidx   = sidx_q;
    c_scount = scount_q;
    c_cmd    = cmd_q;
    c_ferr   = ferr_q;
    c_closed = closed_q;
    if (item_i.connection_start) begin
      c_phase  = PhLen;
      c_hdr    = '0;
      c_shift  = '0;
      c_flen   = '0;
      c_fpos   = '0;
      c_sleft  = '0;
      c_sbytes = '0;
      c_sidx   = '0;
      c_scount = '0;
      c_cmd    = 3'b111;
      c_ferr   = 1'b0;
      c_closed = 1'b0;
    end

    phase_d  = c_phase;
    hdr_d    = c_hdr;
    shift_d  = c_shift;
    flen_d   = c_flen;
    fpos_d   = c_fpos;
    sleft_d  = c_sleft;
    sbytes_d = c_sbytes;
    sidx_d   = c_sidx;
    scount_d = c_scount;
    cmd_d    = c_cmd;
    ferr_d   = c_ferr;
    closed_d = c_closed;

    res               = '0;
    res.byte_out      = item_i.stream_byte;
    res.verdict       = lprp_pkg::VerdictNone;

    // Little-endian header field collection.
    full      = c_shift | (32'(item_i.stream_byte) << {c_hdr, 3'b000});
    done      = (c_hdr == 2'd3);
    too_big   = (full > 32'(max_message_i)) || (full > lprp_pkg::CntMax);
    pos1      = c_fpos + CW'(1);
    last      = (pos1 == c_flen);
    sleft_m1  = c_sleft - CW'(1);
    sidx_p1   = c_sidx + CW'(1);
    sbytes_m1 = c_sbytes - CW'(1);
    off       = 2'd3 - c_sbytes[1:0];
    low       = lprp_pkg::fold_case(item_i.stream_byte);

    if (c_closed) begin
      // Closed stream: bytes pass through only.
    end else if (c_phase == PhLen) begin
      if (done) begin
        hdr_d   = '0;
        shift_d = '0;
        if (too_big) begin
          res.frame_end = 1'b1;
          res.verdict   = lprp_pkg::VerdictLong;
          closed_d      = 1'b1;
        end else if (full == 32'd0) begin
          res.frame_end = 1'b1;
          res.verdict   = lprp_pkg::VerdictBad;
          closed_d      = 1'b1;
        end else begin
          flen_d   = full[CW-1:0];
          fpos_d   = '0;
          sleft_d  = '0;
          sbytes_d = '0;
          sidx_d   = '0;
          scount_d = '0;
          cmd_d    = 3'b111;
          ferr_d   = 1'b0;
          phase_d  = PhCnt;
        end
      end else begin
        hdr_d   = c_hdr + 2'd1;
        shift_d = full;
      end
    end else begin
      fpos_d = pos1;
      unique case (c_phase)
        PhCnt: begin
          if (done) begin
            hdr_d   = '0;
            shift_d = '0;
            if (too_big) begin
              ferr_d  = 1'b1;
              phase_d = PhTail;
            end else begin
              scount_d = full[CW-1:0];
              sleft_d  = full[CW-1:0];
              sidx_d   = '0;
              phase_d  = (full != 32'd0) ? PhShdr : PhTail;
            end
          end else begin
            hdr_d   = c_hdr + 2'd1;
            shift_d = full;
          end
        end
        PhShdr: begin
          if (done) begin
            hdr_d   = '0;
            shift_d = '0;
            if ((pos1 > c_flen) || (full > 32'(c_flen - pos1))) begin
              ferr_d  = 1'b1;
              phase_d = PhTail;
            end else begin
              if (c_sidx == '0 && full != 32'd3) begin
                cmd_d = 3'b000;
              end
              if (full == 32'd0) begin
                // Empty string: straight on to the next header.
                sleft_d = sleft_m1;
                sidx_d  = sidx_p1;
                phase_d = (sleft_m1 != '0) ? PhShdr : PhTail;
              end else begin
                sbytes_d = full[CW-1:0];
                phase_d  = PhSdata;
              end
            end
          end else begin
            hdr_d   = c_hdr + 2'd1;
            shift_d = full;
          end
        end
        PhSdata: begin
          res.payload_valid = 1'b1;
          res.string_number = c_sidx;
          // Command letters are checked on the first string only.
          if (c_sidx == '0 && c_cmd != 3'b000 && c_sbytes >= CW'(1) &&
              c_sbytes <= CW'(3)) begin
            for (int k = 0; k < 3; k++) begin
              if (lprp_pkg::CmdChars[k][off] != low) begin
                cmd_d[k] = 1'b0;
              end
            end
          end
          sbytes_d = sbytes_m1;
          if (sbytes_m1 == '0) begin
            res.string_last = 1'b1;
            sleft_d = sleft_m1;
            sidx_d  = sidx_p1;
            phase_d = (sleft_m1 != '0) ? PhShdr : PhTail;
          end
        end
        default: begin
          // Bytes after the last string.
          ferr_d  = 1'b1;
          phase_d = PhTail;
        end
      endcase

      // Verdict on the frame's last byte.
      if (last) begin
        res.frame_end = 1'b1;
        if (ferr_d || phase_d != PhTail) begin
          res.verdict = lprp_pkg::VerdictBad;
          closed_d    = 1'b1;
        end else if (scount_d == CW'(2) && cmd_d[0]) begin
          res.verdict = lprp_pkg::VerdictGet;
        end else if (scount_d == CW'(3) && cmd_d[1]) begin
          res.verdict = lprp_pkg::VerdictSet;
        end else if (scount_d == CW'(2) && cmd_d[2]) begin
          res.verdict = lprp_pkg::VerdictDel;
        end else begin
          res.verdict = lprp_pkg::VerdictUnknown;
        end
        phase_d = PhLen;
        hdr_d   = '0;
        shift_d = '0;
      end
    end

    res.stream_closed = closed_d;
  end

  assign result_o = res;

  // Parse state, advanced once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhLen;
      hdr_q    <= '0;
      shift_q  <= '0;
      flen_q   <= '0;
      fpos_q   <= '0;
      sleft_q  <= '0;
      sbytes_q <= '0;
      sidx_q   <= '0;
      scount_q <= '0;
      cmd_q    <= 3'b111;
      ferr_q   <= 1'b0;
      closed_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      shift_q  <= shift_d;
      flen_q   <= flen_d;
      fpos_q   <= fpos_d;
      sleft_q  <= sleft_d;
      sbytes_q <= sbytes_d;
      sidx_q   <= sidx_d;
      scount_q <= scount_d;
      cmd_q    <= cmd_d;
      ferr_q   <= ferr_d;
      closed_q <= closed_d;
    end
  end

  `LPRP_ASSERT(a_closed_sticks, clk_i, rst_ni, closed_q && !(step_i && item_i.connection_start) |=> closed_q, "closed stream reopened without a connection start")
  `LPRP_ASSERT(a_fatal_closes, clk_i, rst_ni, step_i && (result_o.verdict == lprp_pkg::VerdictBad || result_o.verdict == lprp_pkg::VerdictLong) |-> result_o.stream_closed && result_o.frame_end, "fatal verdict did not close the stream")
  `LPRP_ASSERT(a_payload_in_data, clk_i, rst_ni, step_i && result_o.payload_valid |-> phase_q == PhSdata, "payload byte outside string data")
  `LPRP_ASSERT(a_verdict_at_end, clk_i, rst_ni, step_i && result_o.verdict != lprp_pkg::VerdictNone |-> result_o.frame_end, "verdict without frame end")
  `LPRP_ASSERT_AR(a_reset_clears, clk_i, !rst_ni && $past(!rst_ni) |-> !closed_q && phase_q == PhLen, "reset did not clear the parse state")

endmodule

FILE: rtl/length_prefixed_request_parser.sv
// Length-prefixed request parser.
// req_i carries one byte of a connection stream per transaction, with
// connection_start marking the first byte of a new connection. res_o carries
// one result transaction per input byte: the byte passed through, its string
// tags, and on the last byte of a frame the verdict (get, set, del, unknown
// command, bad request, too long).
// cfg_we_i/cfg_wdata_i write max_message, the limit on frame body length and
// string count; write it only while the parser is idle.
// An accepted byte waits in the input register, then the step logic writes its
// result into the result register. Throughput is one byte per cycle while
// res_o.ready stays high; the parse state update is the only loop.
// Reset clears the parse state, max_message returns to 4096, and both
// registers are emptied. When the receiver holds res_o.ready low, the result
// waits in the output register, one more byte is held in the input register,
// and then req_i.ready drops until the result is taken.
module length_prefixed_request_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lprp_in_if.sink                         req_i,
  lprp_out_if.source                      res_o,
  input  logic                            cfg_we_i,
  input  logic [lprp_pkg::CountWidth-1:0] cfg_wdata_i
);

  logic [lprp_pkg::CountWidth-1:0] max_msg_q;
  logic                            in_vld_q;
  lprp_pkg::item_t                 in_item_q;
  logic                            out_vld_q;
  lprp_pkg::result_t               out_res_q;
  lprp_pkg::result_t               step_res;
  logic                            advance;
  logic                            in_take;

  // A byte moves to the result register when that register is free or drains.
  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign in_take     = req_i.valid && req_i.ready;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q <= lprp_pkg::MaxMessageReset;
    end else if (cfg_we_i) begin
      max_msg_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.connection_start <= req_i.connection_start;
      in_item_q.stream_byte      <= req_i.stream_byte;
    end
  end

  lprp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_item_q),
    .max_message_i (max_msg_q),
    .result_o      (step_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.byte_out      = out_res_q.byte_out;
  assign res_o.payload_valid = out_res_q.payload_valid;
  assign res_o.string_number = out_res_q.string_number;
  assign res_o.string_last   = out_res_q.string_last;
  assign res_o.frame_end     = out_res_q.frame_end;
  assign res_o.verdict       = out_res_q.verdict;
  assign res_o.stream_closed = out_res_q.stream_closed;

endmodule
